### rtl/core/mrpt_pkg.sv
package mrpt_pkg;

   // Width of the arithmetic; candidate bits above it are ignored.
   localparam int NUM_WIDTH = 64;

   // Port field widths.
   localparam int CAND_W      = 64;
   localparam int RSP_TDATA_W = 8;

   // Bit counts; only TWOS_W is derived from the arithmetic width.
   localparam int TWOS_W  = $clog2(NUM_WIDTH);
   localparam int BASE_W  = 6;
   localparam int IDX_W   = 4;
   localparam int BOUND_W = 64;

   // Base table positions with a special meaning.
   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(11);
   localparam logic [IDX_W-1:0] REJECT_IDX = IDX_W'(3);

   // Strong pseudoprime to bases 2, 3, 5 and 7 that lies below the next bound.
   localparam logic [BOUND_W-1:0] SPSP_2357 = BOUND_W'(64'd3215031751);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SPLIT,
      ST_ROUND,
      ST_EXP,
      ST_EXP_MUL,
      ST_EXP_SQR,
      ST_EVAL,
      ST_SQ,
      ST_SQ_WAIT,
      ST_NEXT,
      ST_FINISH
   } state_type;

   // Witness base tried at each position of the sequence.
   function automatic logic [BASE_W-1:0] base_of(input logic [IDX_W-1:0] idx);
      logic [BASE_W-1:0] b;
      case (idx)
         4'd0:    b = 6'd2;
         4'd1:    b = 6'd3;
         4'd2:    b = 6'd5;
         4'd3:    b = 6'd7;
         4'd4:    b = 6'd11;
         4'd5:    b = 6'd13;
         4'd6:    b = 6'd17;
         4'd7:    b = 6'd19;
         4'd8:    b = 6'd23;
         4'd9:    b = 6'd29;
         4'd10:   b = 6'd31;
         4'd11:   b = 6'd37;
         default: b = 6'd2;
      endcase
      return b;
   endfunction

   // Candidates below this bound are accepted once the base at idx has passed.
   // Zero means there is no early acceptance after that base.
   function automatic logic [BOUND_W-1:0] bound_of(input logic [IDX_W-1:0] idx);
      logic [BOUND_W-1:0] b;
      case (idx)
         4'd1:    b = 64'd1373653;
         4'd2:    b = 64'd25326001;
         4'd3:    b = 64'd25000000000;
         4'd4:    b = 64'd2152302898747;
         4'd5:    b = 64'd3474749660383;
         4'd6:    b = 64'd341550071728321;
         default: b = '0;
      endcase
      return b;
   endfunction

   // Modular sum of two residues below m; the carry is kept so that any m works.
   function automatic logic [NUM_WIDTH-1:0] add_mod(input logic [NUM_WIDTH-1:0] a,
                                                    input logic [NUM_WIDTH-1:0] b,
                                                    input logic [NUM_WIDTH-1:0] m);
      logic [NUM_WIDTH:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[NUM_WIDTH-1:0];
   endfunction

endpackage

### rtl/core/mrpt_mulmod.sv
module mrpt_mulmod (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [mrpt_pkg::NUM_WIDTH-1:0] op_a,
   input  logic [mrpt_pkg::NUM_WIDTH-1:0] op_b,
   input  logic [mrpt_pkg::NUM_WIDTH-1:0] modulus,
   output logic                           done,
   output logic [mrpt_pkg::NUM_WIDTH-1:0] product
);
   import mrpt_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [NUM_WIDTH-1:0] acc_ff, acc_in;
   logic [NUM_WIDTH-1:0] v_ff, v_in;
   logic [NUM_WIDTH-1:0] b_ff, b_in;

   // One multiplier bit per cycle: add the doubled multiplicand when the bit is set.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      acc_in  = acc_ff;
      v_in    = v_ff;
      b_in    = b_ff;
      if (start) begin
         busy_in = 1'b1;
         acc_in  = '0;
         v_in    = op_a;
         b_in    = op_b;
      end else if (busy_ff) begin
         if (b_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (b_ff[0]) begin
               acc_in = add_mod(acc_ff, v_ff, modulus);
            end
            v_in = add_mod(v_ff, v_ff, modulus);
            b_in = b_ff >> 1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath shift registers.
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      v_ff   <= v_in;
      b_ff   <= b_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

### rtl/core/miller_rabin_prime_test.sv
// Deterministic Miller-Rabin primality test. Each word on the req side is a
// 64-bit unsigned candidate; each word on the rsp side carries one flag that is
// 1 when the candidate is prime. One candidate is worked on at a time, and a
// new one is taken while the previous result still waits on the rsp side. The
// time per candidate is set by the single bit-serial modular multiplier, which
// handles one multiplier bit a cycle. A round with one base needs up to two
// products per bit of the odd part of candidate - 1 for the modular power plus
// one squaring per trailing zero of candidate - 1, so at most 2 * NUM_WIDTH
// products; up to twelve bases are tried, so a large prime runs all twelve
// rounds, while small values and most composites finish far sooner (below 2,
// 2 and 3 skip the rounds).
module miller_rabin_prime_test (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mrpt_pkg::CAND_W-1:0]         req_tdata,   // [63:0] candidate
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mrpt_pkg::RSP_TDATA_W-1:0]    rsp_tdata    // [0] prime flag, rest zero
);
   import mrpt_pkg::*;

   state_type            state_ff, state_in;
   logic [NUM_WIDTH-1:0] n_ff, n_in;
   logic [NUM_WIDTH-1:0] nm1_ff, nm1_in;
   logic [NUM_WIDTH-1:0] d_ff, d_in;
   logic [TWOS_W-1:0]    twos_ff, twos_in;
   logic [NUM_WIDTH-1:0] e_ff, e_in;
   logic [NUM_WIDTH-1:0] x_ff, x_in;
   logic [NUM_WIDTH-1:0] v_ff, v_in;
   logic [TWOS_W-1:0]    cnt_ff, cnt_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_flag_ff, rsp_flag_in;

   logic                 mul_start;
   logic [NUM_WIDTH-1:0] mul_a;
   logic [NUM_WIDTH-1:0] mul_b;
   logic                 mul_done;
   logic [NUM_WIDTH-1:0] mul_p;
   logic [NUM_WIDTH-1:0] cand;
   logic [BOUND_W-1:0]   n_wide;

   assign cand   = req_tdata[NUM_WIDTH-1:0];
   assign n_wide = BOUND_W'(n_ff);

   // Shared modular multiplier.
   mrpt_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .modulus (n_ff),
      .done    (mul_done),
      .product (mul_p)
   );

   // Sequencer: split n - 1, run the modular power, then the squaring chain.
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      nm1_in       = nm1_ff;
      d_in         = d_ff;
      twos_in      = twos_ff;
      e_in         = e_ff;
      x_in         = x_ff;
      v_in         = v_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_flag_in  = rsp_flag_ff;
      mul_start    = 1'b0;
      mul_a        = x_ff;
      mul_b        = v_ff;
      req_tready   = 1'b0;

      // The result word leaves when the sink takes it.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_tready = !reset;
            if (req_tvalid && req_tready) begin
               n_in    = cand;
               nm1_in  = cand - NUM_WIDTH'(1);
               d_in    = cand - NUM_WIDTH'(1);
               twos_in = '0;
               idx_in  = '0;
               if (cand < NUM_WIDTH'(2)) begin
                  res_in   = 1'b0;
                  state_in = ST_FINISH;
               end else if (cand < NUM_WIDTH'(4)) begin
                  res_in   = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SPLIT;
               end
            end
         end
         // Strip the factors of two from n - 1, one per cycle.
         ST_SPLIT: begin
            if (!d_ff[0]) begin
               d_in    = d_ff >> 1;
               twos_in = twos_ff + TWOS_W'(1);
            end else begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            e_in     = d_ff;
            x_in     = NUM_WIDTH'(1);
            v_in     = NUM_WIDTH'(base_of(idx_ff));
            cnt_in   = twos_ff;
            state_in = ST_EXP;
         end
         // Exponent bits are consumed from the low end.
         ST_EXP: begin
            if (e_ff == '0) begin
               state_in = ST_EVAL;
            end else if (e_ff[0]) begin
               mul_start = 1'b1;
               mul_a     = x_ff;
               mul_b     = v_ff;
               state_in  = ST_EXP_MUL;
            end else begin
               mul_start = 1'b1;
               mul_a     = v_ff;
               mul_b     = v_ff;
               state_in  = ST_EXP_SQR;
            end
         end
         ST_EXP_MUL: begin
            if (mul_done) begin
               x_in      = mul_p;
               mul_start = 1'b1;
               mul_a     = v_ff;
               mul_b     = v_ff;
               state_in  = ST_EXP_SQR;
            end
         end
         ST_EXP_SQR: begin
            if (mul_done) begin
               v_in     = mul_p;
               e_in     = e_ff >> 1;
               state_in = ST_EXP;
            end
         end
         ST_EVAL: begin
            if (x_ff == NUM_WIDTH'(1) || x_ff == nm1_ff) begin
               state_in = ST_NEXT;
            end else begin
               state_in = ST_SQ;
            end
         end
         // Repeated squaring looks for n - 1.
         ST_SQ: begin
            if (cnt_ff == '0) begin
               res_in   = 1'b0;
               state_in = ST_FINISH;
            end else begin
               mul_start = 1'b1;
               mul_a     = x_ff;
               mul_b     = x_ff;
               cnt_in    = cnt_ff - TWOS_W'(1);
               state_in  = ST_SQ_WAIT;
            end
         end
         ST_SQ_WAIT: begin
            if (mul_done) begin
               x_in = mul_p;
               if (mul_p == nm1_ff) begin
                  state_in = ST_NEXT;
               end else begin
                  state_in = ST_SQ;
               end
            end
         end
         // The base passed; decide whether more bases are needed.
         ST_NEXT: begin
            if (idx_ff == LAST_IDX) begin
               res_in   = 1'b1;
               state_in = ST_FINISH;
            end else if (idx_ff == REJECT_IDX && n_wide == SPSP_2357) begin
               res_in   = 1'b0;
               state_in = ST_FINISH;
            end else if (n_wide < bound_of(idx_ff)) begin
               res_in   = 1'b1;
               state_in = ST_FINISH;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_ROUND;
            end
         end
         // Hand the flag to the output register once it is free.
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_flag_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      nm1_ff      <= nm1_in;
      d_ff        <= d_in;
      twos_ff     <= twos_in;
      e_ff        <= e_in;
      x_ff        <= x_in;
      v_ff        <= v_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      res_ff      <= res_in;
      rsp_flag_ff <= rsp_flag_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-1){1'b0}}, rsp_flag_ff};

endmodule
